[src/bgcd_pkg.sv]
// Shared constants, types and helpers of the binary GCD block.
`timescale 1ns / 1ps

package bgcd_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int KEEP_W = $clog2(DATA_WIDTH);
	localparam int SHIFT_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;
	localparam int FLIGHT_W = $clog2(MAX_INFLIGHT + 2);
	localparam logic [7:0] LOW_BYTE_MASK = 8'hff;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// One classified item, as the front hands it to the back.
	typedef struct packed {
		word_t mag_a;
		word_t mag_b;
		logic  a_zero;
		logic  b_zero;
	} item_t;

	// Trailing zeros of one byte, 8 when the byte is zero.
	function automatic logic [SHIFT_W-1:0] ctz8(input logic [7:0] v);
		logic [SHIFT_W-1:0] n;
		n = SHIFT_W'(8);
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				n = SHIFT_W'(i);
			end
		end
		return n;
	endfunction

endpackage

[src/bgcd_in_if.sv]
// Operand channel: valid, ready and both signed operands.
`timescale 1ns / 1ps

interface bgcd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [bgcd_pkg::DATA_WIDTH-1:0]  operand_a;
	logic signed [bgcd_pkg::DATA_WIDTH-1:0]  operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

[src/bgcd_out_if.sv]
// Result channel: valid, ready and the unsigned gcd value.
`timescale 1ns / 1ps

interface bgcd_out_if;
	logic                 valid;
	logic                 ready;
	bgcd_pkg::word_t      gcd_value;

	modport source (output valid, output gcd_value, input ready);
	modport sink (input valid, input gcd_value, output ready);
endinterface

[src/bgcd_front.sv]
// Front end: takes operand transactions, forms magnitudes and flags zeros.
`timescale 1ns / 1ps

module bgcd_front (
	bgcd_in_if.sink          operands,
	output logic             push_valid,
	input  logic             push_ready,
	output bgcd_pkg::item_t  push_item
);

	bgcd_pkg::word_t raw_a;
	bgcd_pkg::word_t raw_b;
	bgcd_pkg::word_t mag_a;
	bgcd_pkg::word_t mag_b;

	assign raw_a = operands.operand_a;
	assign raw_b = operands.operand_b;

	// Unsigned negate, so the most negative value maps to 2^(W-1).
	assign mag_a = raw_a[bgcd_pkg::DATA_WIDTH-1] ? (~raw_a + 1'b1) : raw_a;
	assign mag_b = raw_b[bgcd_pkg::DATA_WIDTH-1] ? (~raw_b + 1'b1) : raw_b;

	assign push_valid       = operands.valid;
	assign operands.ready   = push_ready;
	assign push_item.mag_a  = mag_a;
	assign push_item.mag_b  = mag_b;
	assign push_item.a_zero = (raw_a == '0);
	assign push_item.b_zero = (raw_b == '0);

endmodule

[src/bgcd_queue.sv]
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module bgcd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bgcd_pkg::item_t  push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bgcd_pkg::item_t  pop_item
);

	bgcd_pkg::item_t                 slot_q [bgcd_pkg::QUEUE_DEPTH];
	logic [bgcd_pkg::QPTR_W-1:0]     wptr_q;
	logic [bgcd_pkg::QPTR_W-1:0]     rptr_q;
	logic [bgcd_pkg::QCNT_W-1:0]     count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != bgcd_pkg::QCNT_W'(bgcd_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rptr_q];

	function automatic logic [bgcd_pkg::QPTR_W-1:0] next_ptr(
		input logic [bgcd_pkg::QPTR_W-1:0] p
	);
		if (p == bgcd_pkg::QPTR_W'(bgcd_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule

[src/bgcd_back.sv]
// Back end: iterative Stein engine with an output register.
`timescale 1ns / 1ps

module bgcd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  bgcd_pkg::item_t  pop_item,
	bgcd_out_if.source       result
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_COMMON = 3'b010,
		ST_REDUCE = 3'b100
	} state_t;

	state_t                          state_q;
	bgcd_pkg::word_t                 a_q;
	bgcd_pkg::word_t                 b_q;
	logic [bgcd_pkg::KEEP_W-1:0]     keep_q;
	bgcd_pkg::word_t                 result_q;
	logic                            out_valid_q;

	logic                            out_free;
	logic                            zero_case;
	logic                            load_out;
	logic [bgcd_pkg::SHIFT_W-1:0]    n_common;
	logic [bgcd_pkg::SHIFT_W-1:0]    n_a;
	logic [bgcd_pkg::SHIFT_W-1:0]    n_b;
	logic [bgcd_pkg::DATA_WIDTH:0]   diff_ab;
	bgcd_pkg::word_t                 diff_ba;
	logic                            equal;

	assign out_free  = !out_valid_q || result.ready;
	assign zero_case = pop_item.a_zero || pop_item.b_zero;

	// Zero items finish at once, so take them only when the output slot is free.
	assign pop_ready = (state_q == ST_IDLE) && (!zero_case || out_free);

	assign n_common = bgcd_pkg::ctz8((a_q[7:0] | b_q[7:0]) & bgcd_pkg::LOW_BYTE_MASK);
	assign n_a      = bgcd_pkg::ctz8(a_q[7:0]);
	assign n_b      = bgcd_pkg::ctz8(b_q[7:0]);
	assign diff_ab  = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba  = b_q - a_q;
	assign equal    = (diff_ab == '0);

	assign load_out = (pop_valid && pop_ready && zero_case)
		|| ((state_q == ST_REDUCE) && a_q[0] && b_q[0] && equal && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_ready && !zero_case) begin
						state_q <= ST_COMMON;
					end
				end
				ST_COMMON: begin
					if (a_q[0] || b_q[0]) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid && pop_ready) begin
					a_q    <= pop_item.mag_a;
					b_q    <= pop_item.mag_b;
					keep_q <= '0;
					if (zero_case) begin
						result_q <= pop_item.a_zero ? pop_item.mag_b : pop_item.mag_a;
					end
				end
			end
			ST_COMMON: begin
				// Strip shared factors of two, up to a byte per cycle.
				if (!(a_q[0] || b_q[0])) begin
					a_q    <= a_q >> n_common;
					b_q    <= b_q >> n_common;
					keep_q <= keep_q + bgcd_pkg::KEEP_W'(n_common);
				end
			end
			ST_REDUCE: begin
				if (!a_q[0]) begin
					a_q <= a_q >> n_a;
				end else if (!b_q[0]) begin
					b_q <= b_q >> n_b;
				end else if (equal) begin
					if (out_free) begin
						result_q <= a_q << keep_q;
					end
				end else if (diff_ab[bgcd_pkg::DATA_WIDTH]) begin
					b_q <= diff_ba;
				end else begin
					a_q <= diff_ab[bgcd_pkg::DATA_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid     = out_valid_q;
	assign result.gcd_value = result_q;

endmodule

[src/binary_gcd.sv]
// Top level of the binary GCD block: front, queue and Stein engine.
`timescale 1ns / 1ps

// Binary GCD (Stein). Each operand transaction carries two signed words; the
// block returns one result transaction with the gcd of their magnitudes, in
// order. The magnitude of the most negative word is taken as the unsigned
// value 2^(W-1). If one operand is zero the result is the other magnitude,
// and zero when both are zero; such items go straight to the output register.
// For other items the engine takes the item, strips shared trailing zero bits
// up to eight at a time, then shifts out trailing zeros of each operand and
// subtracts the smaller from the larger until both are equal, and finishes,
// so the time per item is data dependent. The engine works on one item at a
// time; a two-entry queue in front of it accepts further operands while it
// runs, and an output register holds a finished result while the engine
// goes on.
// No clearing pass is needed after reset.
module binary_gcd (
	input  logic        clk,
	input  logic        arst_n,
	bgcd_in_if.sink     operands,
	bgcd_out_if.source  result
);

	logic             push_valid;
	logic             push_ready;
	bgcd_pkg::item_t  push_item;
	logic             pop_valid;
	logic             pop_ready;
	bgcd_pkg::item_t  pop_item;

	// Classify each operand transaction as it arrives.
	bgcd_front u_front (
		.operands   (operands),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Hold classified items so the front can stall independently of the engine.
	bgcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Run the subtract-and-shift loop and drive the result channel.
	bgcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.result    (result)
	);

endmodule

[src/bgcd_checker.sv]
// Port-level checker for the binary GCD block, bound to the top level.
`timescale 1ns / 1ps

module bgcd_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             out_valid,
	input  logic             out_ready,
	input  bgcd_pkg::word_t  gcd_value
);

	logic [bgcd_pkg::FLIGHT_W-1:0] inflight_q;
	logic                          in_acc;
	logic                          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(gcd_value))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without an outstanding operand transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= bgcd_pkg::FLIGHT_W'(bgcd_pkg::MAX_INFLIGHT))
		else $error("more transactions in flight than the block can hold");

endmodule

bind binary_gcd bgcd_checker u_bgcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operands.valid),
	.in_ready  (operands.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.gcd_value (result.gcd_value)
);
